### design/sirs_pkg.sv
// Shared types, constants and alphabet helpers for the radix symbol converter.
package sirs_pkg;

  localparam int MAX_RADIX   = 16;
  localparam int VAL_W       = 32;
  localparam int SYM_W       = 8;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int ALPHA_W     = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int STACK_DEPTH = 32;
  localparam int STACK_AW    = 5;
  localparam int CNT_W       = 6;
  localparam int DIV_STEPS   = 8;
  localparam int CHUNK_W     = 2;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } back_state_t;

  // Classified item passed from the front to the back
  typedef struct packed {
    logic [VAL_W-1:0] mag;
    logic             neg;
    logic             invalid;
  } work_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             base_invalid;
  } result_t;

  function automatic logic [SYM_W-1:0] symbol_at(input logic [DIGIT_W-1:0] k,
                                                 input logic [ALPHA_W-1:0] lo,
                                                 input logic [ALPHA_W-1:0] hi);
    logic [ALPHA_W-1:0] half;
    half = k[3] ? hi : lo;
    return half[{k[2:0], 3'b000} +: SYM_W];
  endfunction

  function automatic logic alphabet_ok(input logic [RADIX_W-1:0] radix,
                                       input logic [ALPHA_W-1:0] lo,
                                       input logic [ALPHA_W-1:0] hi);
    logic [2*ALPHA_W-1:0] tab;
    logic                 ok;
    logic [SYM_W-1:0]     si;
    tab = {hi, lo};
    ok  = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      si = tab[SYM_W*i +: SYM_W];
      if (RADIX_W'(i) < radix) begin
        if (si == SYM_PLUS || si == SYM_MINUS || si == SYM_NUL) ok = 1'b0;
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_W'(j) < radix && tab[SYM_W*j +: SYM_W] == si) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

### design/sirs_front.sv
// Front end: takes input values, checks the alphabet and forms the magnitude.
module sirs_front (
  input  logic signed [sirs_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [sirs_pkg::RADIX_W-1:0]        radix_i,
  input  logic [sirs_pkg::ALPHA_W-1:0]        alpha_lo_i,
  input  logic [sirs_pkg::ALPHA_W-1:0]        alpha_hi_i,
  input  logic                                q_full,
  output logic                                q_push,
  output sirs_pkg::work_item_t                q_item
);
  import sirs_pkg::*;

  logic [VAL_W-1:0] raw;

  assign raw     = VAL_W'(in_value);
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_item.neg     = raw[VAL_W-1];
    // two's complement negate as unsigned covers the minimum integer
    q_item.mag     = raw[VAL_W-1] ? (VAL_W'(0) - raw) : raw;
    q_item.invalid = !alphabet_ok(radix_i, alpha_lo_i, alpha_hi_i);
  end

endmodule

### design/sirs_queue.sv
// Two-entry queue of classified items between front and back.
module sirs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sirs_pkg::work_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output sirs_pkg::work_item_t pop_item
);
  import sirs_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  work_item_t entry_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == DEPTH);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = entry_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wp_r] <= push_item;
  end

endmodule

### design/sirs_back.sv
// Back end: digit division, digit stack and symbol output queue.
module sirs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sirs_pkg::RADIX_W-1:0]  radix_i,
  input  logic [sirs_pkg::ALPHA_W-1:0]  alpha_lo_i,
  input  logic [sirs_pkg::ALPHA_W-1:0]  alpha_hi_i,
  input  logic                          q_empty,
  input  sirs_pkg::work_item_t          q_item,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [sirs_pkg::SYM_W-1:0]    out_symbol,
  output logic                          out_last,
  output logic                          out_base_invalid
);
  import sirs_pkg::*;

  localparam logic [1:0]         OUT_DEPTH  = 2'd2;
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(VAL_W / DIV_STEPS - 1);

  back_state_t          state_r, state_nxt;
  logic [VAL_W-1:0]     w_r, w_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [CHUNK_W-1:0]   chunk_r, chunk_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 rd_pend_r;
  logic                 rd_last_r, rd_last_nxt;
  logic [DIGIT_W-1:0]   rd_data_r;

  logic [DIGIT_W-1:0]   stack_mem [STACK_DEPTH];
  logic                 st_we;
  logic [STACK_AW-1:0]  st_waddr;
  logic                 rd_en;
  logic [STACK_AW-1:0]  rd_addr;
  logic [CNT_W-1:0]     cnt_dec;

  logic [VAL_W-1:0]     div_w;
  logic [DIGIT_W-1:0]   div_rem;

  result_t              ofifo_r [2];
  logic                 owp_r, orp_r;
  logic [1:0]           ocnt_r, ocnt_nxt;
  logic                 dir_push;
  result_t              dir_res;
  logic                 push, pop;
  result_t              push_res;

  // Eight restoring-division steps per cycle; quotient bits shift into w
  always_comb begin
    logic [RADIX_W-1:0] t;
    div_w   = w_r;
    div_rem = rem_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {div_rem, div_w[VAL_W-1]};
      div_w = {div_w[VAL_W-2:0], 1'b0};
      if (t >= radix_i) begin
        div_rem  = DIGIT_W'(t - radix_i);
        div_w[0] = 1'b1;
      end else begin
        div_rem = t[DIGIT_W-1:0];
      end
    end
  end

  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign rd_addr  = cnt_dec[STACK_AW-1:0];
  assign st_waddr = cnt_r[STACK_AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    w_nxt       = w_r;
    rem_nxt     = rem_r;
    chunk_nxt   = chunk_r;
    cnt_nxt     = cnt_r;
    neg_nxt     = neg_r;
    rd_last_nxt = rd_last_r;
    q_pop       = 1'b0;
    st_we       = 1'b0;
    rd_en       = 1'b0;
    dir_push    = 1'b0;
    dir_res     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && !rd_pend_r && ocnt_r != OUT_DEPTH) begin
          q_pop = 1'b1;
          if (q_item.invalid) begin
            dir_push             = 1'b1;
            dir_res.symbol       = SYM_NUL;
            dir_res.last         = 1'b1;
            dir_res.base_invalid = 1'b1;
          end else begin
            w_nxt     = q_item.mag;
            rem_nxt   = '0;
            chunk_nxt = '0;
            cnt_nxt   = '0;
            neg_nxt   = q_item.neg;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        w_nxt     = div_w;
        rem_nxt   = div_rem;
        chunk_nxt = chunk_r + CHUNK_W'(1);
        if (chunk_r == CHUNK_LAST) begin
          st_we   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          rem_nxt = '0;
          if (div_w == '0 || cnt_r >= CNT_W'(STACK_DEPTH - 1)) begin
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (ocnt_r != OUT_DEPTH) begin
          dir_push       = 1'b1;
          dir_res.symbol = SYM_MINUS;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // count the read in flight against free output slots
        if (ocnt_r == 2'd0 || (ocnt_r == 2'd1 && !rd_pend_r)) begin
          rd_en       = 1'b1;
          cnt_nxt     = cnt_dec;
          rd_last_nxt = (cnt_r == CNT_W'(1));
          if (cnt_r == CNT_W'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      chunk_r   <= '0;
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chunk_r   <= chunk_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    rem_r     <= rem_nxt;
    neg_r     <= neg_nxt;
    rd_last_r <= rd_last_nxt;
  end

  // Digit stack
  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_waddr] <= div_rem;
    if (rd_en) rd_data_r <= stack_mem[rd_addr];
  end

  // Output queue
  always_comb begin
    if (rd_pend_r) begin
      push_res.symbol       = symbol_at(rd_data_r, alpha_lo_i, alpha_hi_i);
      push_res.last         = rd_last_r;
      push_res.base_invalid = 1'b0;
    end else begin
      push_res = dir_res;
    end
  end

  assign push     = rd_pend_r || dir_push;
  assign pop      = out_pop && (ocnt_r != 2'd0);
  assign ocnt_nxt = ocnt_r + {1'b0, push} - {1'b0, pop};

  assign out_empty        = (ocnt_r == 2'd0);
  assign out_symbol       = ofifo_r[orp_r].symbol;
  assign out_last         = ofifo_r[orp_r].last;
  assign out_base_invalid = ofifo_r[orp_r].base_invalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (push) owp_r <= !owp_r;
      if (pop) orp_r <= !orp_r;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ofifo_r[owp_r] <= push_res;
  end

`ifndef SYNTHESIS
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && ocnt_r == OUT_DEPTH))
    else $error("output queue overflow");

  a_read_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (cnt_r != '0))
    else $error("digit stack read while empty");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ({1'b0, rem_r} < radix_i))
    else $error("partial remainder not below radix");

  a_push_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(dir_push && rd_pend_r))
    else $error("two result sources in one cycle");
`endif

endmodule

### design/signed_int_to_radix_symbols.sv
// The divider forms each digit at 8 quotient bits a cycle; once the last digit is stored, a sign
// symbol leaves first, then the digits from the stack, the most significant first; even with
// out_pop held high, the two-entry output queue can hold off a stack read.
// The back end takes the next value from the queue only once it is done with the last one;
// an invalid alphabet yields a single base_invalid result. The divider sets the pace.
// Reset: synchronous active-low rst_n clears configuration, control state and queues only.
module signed_int_to_radix_symbols (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [sirs_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_push,
  output logic                                in_full,
  output logic [sirs_pkg::SYM_W-1:0]          out_symbol,
  output logic                                out_last,
  output logic                                out_base_invalid,
  output logic                                out_empty,
  input  logic                                out_pop,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sirs_pkg::ALPHA_W-1:0]        cfg_data
);
  import sirs_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic [ALPHA_W-1:0] alpha_lo_r;
  logic [ALPHA_W-1:0] alpha_hi_r;

  logic       q_full, q_push, q_pop, q_empty;
  work_item_t q_in_item, q_out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= '0;
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIX:    radix_r    <= cfg_data[RADIX_W-1:0];
        REG_ALPHA_LO: alpha_lo_r <= cfg_data;
        REG_ALPHA_HI: alpha_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sirs_front u_front (
    .in_value   (in_value),
    .in_push    (in_push),
    .in_full    (in_full),
    .radix_i    (radix_r),
    .alpha_lo_i (alpha_lo_r),
    .alpha_hi_i (alpha_hi_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in_item)
  );

  sirs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_out_item)
  );

  sirs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .radix_i          (radix_r),
    .alpha_lo_i       (alpha_lo_r),
    .alpha_hi_i       (alpha_hi_r),
    .q_empty          (q_empty),
    .q_item           (q_out_item),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_base_invalid (out_base_invalid)
  );

endmodule
